>>> design/assert_macros.svh
// Assertion macros used by the smooth vertex normal top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every rising clock edge outside of reset.
`define SVN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never be true outside of reset.
`define SVN_ASSERT_NEVER(lbl, expr, msg) `SVN_ASSERT(lbl, !(expr), msg)
`endif

>>> design/svn_pkg.sv
// Package with the types, constants and helpers of the smooth vertex normal generator.
package svn_pkg;

	localparam int IDX_W              = 10;
	localparam int POS_W              = 16;
	localparam int NORM_W             = 16;
	localparam int SUM_W              = 48;
	localparam int VERTEX_COUNT_DEF   = 1024;
	localparam int POSITION_BITS_DEF  = 16;
	localparam logic [14:0] UNIT_Q14  = 15'd16384;

	localparam logic signed [63:0] SUM_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] SUM_MIN64 = 64'shFFFF_8000_0000_0000;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_TRI   = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic [IDX_W-1:0]         vertex_id;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic [IDX_W-1:0]         corner_a;
		logic [IDX_W-1:0]         corner_b;
		logic [IDX_W-1:0]         corner_c;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]         out_vertex;
		logic signed [NORM_W-1:0] norm_x;
		logic signed [NORM_W-1:0] norm_y;
		logic signed [NORM_W-1:0] norm_z;
		logic                     zero_sum;
		logic                     sum_clipped;
	} result_t;

	typedef struct packed {
		logic                     done;
		logic                     zero;
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
	} norm_out_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] value;
		logic                    clip;
	} sat_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_T_RA,
		ST_T_RB,
		ST_T_RC,
		ST_T_E2,
		ST_T_MUL,
		ST_T_SRD,
		ST_T_SADD,
		ST_Q_RD,
		ST_Q_START,
		ST_Q_WAIT
	} state_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SCALE,
		N_SQ,
		N_ROOT,
		N_DSET,
		N_DIV,
		N_DONE
	} nstate_t;

	// Saturating add of a face normal component into a 48-bit sum.
	function automatic sat_t sat_add(logic signed [63:0] acc, logic signed [63:0] add);
		logic signed [63:0] s;
		sat_t r;
		s = acc + add;
		r.clip = 1'b0;
		if (s > SUM_MAX64) begin
			r.value = SUM_MAX64[SUM_W-1:0];
			r.clip  = 1'b1;
		end else if (s < SUM_MIN64) begin
			r.value = SUM_MIN64[SUM_W-1:0];
			r.clip  = 1'b1;
		end else begin
			r.value = s[SUM_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> design/svn_ram.sv
// Generic single write port, single read port RAM with registered read data.
module svn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/svn_norm.sv
// Iterative normalizer: scales a sum vector, takes its length and divides it to Q1.14.
module svn_norm (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [svn_pkg::SUM_W-1:0]   sum_x,
	input  logic signed [svn_pkg::SUM_W-1:0]   sum_y,
	input  logic signed [svn_pkg::SUM_W-1:0]   sum_z,
	output svn_pkg::norm_out_t                 nout
);

	svn_pkg::nstate_t state_q, state_d;

	logic [svn_pkg::SUM_W-1:0]          mag_q [3];
	logic [2:0]                         neg_q;
	logic                               zero_q;
	logic [4:0]                         step_q;
	logic [59:0]                        prod_q;
	logic [62:0]                        rem_q;
	logic [62:0]                        res_q;
	logic [62:0]                        bit_q;
	logic [1:0]                         k_q;
	logic [45:0]                        num_q;
	logic [45:0]                        div_q;
	logic [14:0]                        quo_q;
	logic signed [svn_pkg::NORM_W-1:0]  comp_q [3];

	logic [svn_pkg::SUM_W-1:0] mx;
	logic [62:0]               trial;
	logic [29:0]               cur_mag;
	logic                      ge;
	logic [14:0]               quo_next;
	logic [14:0]               clamped;

	always_comb begin
		mx = mag_q[0];
		if (mag_q[1] > mx) begin
			mx = mag_q[1];
		end
		if (mag_q[2] > mx) begin
			mx = mag_q[2];
		end
		trial    = res_q + bit_q;
		cur_mag  = '0;
		case (k_q)
			2'd0:    cur_mag = mag_q[0][29:0];
			2'd1:    cur_mag = mag_q[1][29:0];
			2'd2:    cur_mag = mag_q[2][29:0];
			default: cur_mag = '0;
		endcase
		if (state_q == svn_pkg::N_SQ) begin
			case (step_q[1:0])
				2'd0:    cur_mag = mag_q[0][29:0];
				2'd1:    cur_mag = mag_q[1][29:0];
				2'd2:    cur_mag = mag_q[2][29:0];
				default: cur_mag = '0;
			endcase
		end
		ge       = num_q >= div_q;
		quo_next = {quo_q[13:0], ge};
		clamped  = (quo_next > svn_pkg::UNIT_Q14) ? svn_pkg::UNIT_Q14 : quo_next;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			svn_pkg::N_IDLE: begin
				if (start) begin
					state_d = svn_pkg::N_SCALE;
				end
			end
			svn_pkg::N_SCALE: begin
				if (mx == '0) begin
					state_d = svn_pkg::N_DONE;
				end else if (mx[svn_pkg::SUM_W-1:30] == '0 && mx[29]) begin
					state_d = svn_pkg::N_SQ;
				end
			end
			svn_pkg::N_SQ: begin
				if (step_q == 5'd3) begin
					state_d = svn_pkg::N_ROOT;
				end
			end
			svn_pkg::N_ROOT: begin
				if (bit_q[0]) begin
					state_d = svn_pkg::N_DSET;
				end
			end
			svn_pkg::N_DSET: state_d = svn_pkg::N_DIV;
			svn_pkg::N_DIV: begin
				if (step_q == 5'd14) begin
					state_d = (k_q == 2'd2) ? svn_pkg::N_DONE : svn_pkg::N_DSET;
				end
			end
			svn_pkg::N_DONE: state_d = svn_pkg::N_IDLE;
			default: state_d = svn_pkg::N_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svn_pkg::N_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			svn_pkg::N_IDLE: begin
				if (start) begin
					mag_q[0]  <= sum_x[svn_pkg::SUM_W-1] ? 48'(-sum_x) : 48'(sum_x);
					mag_q[1]  <= sum_y[svn_pkg::SUM_W-1] ? 48'(-sum_y) : 48'(sum_y);
					mag_q[2]  <= sum_z[svn_pkg::SUM_W-1] ? 48'(-sum_z) : 48'(sum_z);
					neg_q     <= {sum_z[svn_pkg::SUM_W-1], sum_y[svn_pkg::SUM_W-1],
						sum_x[svn_pkg::SUM_W-1]};
					comp_q[0] <= '0;
					comp_q[1] <= '0;
					comp_q[2] <= '0;
					zero_q    <= 1'b0;
				end
			end
			svn_pkg::N_SCALE: begin
				step_q <= '0;
				rem_q  <= '0;
				if (mx == '0) begin
					zero_q <= 1'b1;
				end else if (mx[svn_pkg::SUM_W-1:30] != '0) begin
					// A right shift one place at a time truncates like one wide shift.
					mag_q[0] <= mag_q[0] >> 1;
					mag_q[1] <= mag_q[1] >> 1;
					mag_q[2] <= mag_q[2] >> 1;
				end else if (!mx[29]) begin
					mag_q[0] <= mag_q[0] << 1;
					mag_q[1] <= mag_q[1] << 1;
					mag_q[2] <= mag_q[2] << 1;
				end
			end
			svn_pkg::N_SQ: begin
				prod_q <= 60'(cur_mag) * 60'(cur_mag);
				if (step_q != 5'd0) begin
					rem_q <= rem_q + 63'(prod_q);
				end
				step_q <= step_q + 5'd1;
				res_q  <= '0;
				bit_q  <= 63'd1 << 62;
			end
			svn_pkg::N_ROOT: begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				k_q   <= '0;
			end
			svn_pkg::N_DSET: begin
				num_q  <= {2'b00, cur_mag, 14'd0} + 46'(res_q[31:1]);
				div_q  <= {res_q[31:0], 14'd0};
				quo_q  <= '0;
				step_q <= '0;
			end
			svn_pkg::N_DIV: begin
				if (ge) begin
					num_q <= num_q - div_q;
				end
				div_q  <= div_q >> 1;
				quo_q  <= quo_next;
				step_q <= step_q + 5'd1;
				if (step_q == 5'd14) begin
					comp_q[k_q] <= neg_q[k_q] ? -16'(signed'({1'b0, clamped}))
						: 16'(signed'({1'b0, clamped}));
					k_q <= k_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign nout.done = (state_q == svn_pkg::N_DONE);
	assign nout.zero = zero_q;
	assign nout.nx   = comp_q[0];
	assign nout.ny   = comp_q[1];
	assign nout.nz   = comp_q[2];

endmodule

>>> design/smooth_vertex_normal_gen.sv
// Top level of the area-weighted smooth vertex normal generator.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------
//  command   | start, busy        | cmd    (svn_pkg::cmd_t)
//  result    | done (one cycle)   | result (svn_pkg::result_t)
//
// After reset the block sweeps the sum memory to zero, one vertex per cycle, and
// holds busy high meanwhile.
// A position load never raises busy.
// A triangle holds busy through three position reads and the edge setup, six
// products through one multiplier, and a read and a write on the sum memory per
// distinct corner plus a final check; a repeated corner skips its read and write.
// A query holds busy until the normalizer finishes: the sum read, a shift search,
// the squares, a 32-step square root, three divisions and a finish state; an
// all-zero sum goes from the shift search straight to the finish state.
// The receiver cannot stall; each result is shown for exactly one cycle on done,
// in the same cycle that busy falls.
module smooth_vertex_normal_gen #(
	parameter int VERTEX_COUNT  = svn_pkg::VERTEX_COUNT_DEF,
	parameter int POSITION_BITS = svn_pkg::POSITION_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  svn_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done,
	output svn_pkg::result_t result
);

	localparam int AW  = $clog2(VERTEX_COUNT);
	localparam int PB  = POSITION_BITS;
	localparam int DW  = PB + 1;
	localparam int NW  = 2 * DW + 1;
	localparam int PW  = 3 * PB;
	localparam int SW  = svn_pkg::SUM_W;
	localparam int RW  = 3 * SW + 1;

	svn_pkg::state_t state_q, state_d;

	svn_pkg::cmd_t         cmd_q;
	logic [AW-1:0]         clr_q;
	logic signed [PB-1:0]  pa_q [3];
	logic signed [DW-1:0]  e1_q [3];
	logic signed [DW-1:0]  e2_q [3];
	logic [2:0]            mstep_q;
	logic signed [2*DW-1:0] prod_q;
	logic signed [NW-1:0]  n_q [3];
	logic [1:0]            cidx_q;
	logic                  oor_q;
	logic                  clip_q;
	svn_pkg::result_t      result_q;
	logic                  done_q;

	// Memory ports.
	logic          pos_wr_en, pos_rd_en;
	logic [AW-1:0] pos_wr_addr, pos_rd_addr;
	logic [PW-1:0] pos_wr_data, pos_rd_data;
	logic          sum_wr_en, sum_rd_en;
	logic [AW-1:0] sum_wr_addr, sum_rd_addr;
	logic [RW-1:0] sum_wr_data, sum_rd_data;

	logic                  accept;
	logic signed [PB-1:0]  prd [3];
	logic signed [DW-1:0]  mul_a, mul_b;
	logic [1:0]            nsel;
	logic [svn_pkg::IDX_W-1:0] corner;
	logic                  corner_need;
	svn_pkg::sat_t         sat [3];
	logic                  vi_ok, tri_ok;
	svn_pkg::norm_out_t    nout;
	logic                  norm_start;
	logic signed [SW-1:0]  qs [3];

	function automatic logic in_range(logic [svn_pkg::IDX_W-1:0] idx);
		return 32'(idx) < 32'(VERTEX_COUNT);
	endfunction

	assign accept = start && !busy;
	assign busy   = (state_q != svn_pkg::ST_IDLE);
	assign vi_ok  = in_range(cmd.vertex_id);
	assign tri_ok = in_range(cmd.corner_a) && in_range(cmd.corner_b) && in_range(cmd.corner_c);

	svn_ram #(.WIDTH(PW), .DEPTH(VERTEX_COUNT)) u_pos_ram (
		.clk     (clk),
		.wr_en   (pos_wr_en),
		.wr_addr (pos_wr_addr),
		.wr_data (pos_wr_data),
		.rd_en   (pos_rd_en),
		.rd_addr (pos_rd_addr),
		.rd_data (pos_rd_data)
	);

	svn_ram #(.WIDTH(RW), .DEPTH(VERTEX_COUNT)) u_sum_ram (
		.clk     (clk),
		.wr_en   (sum_wr_en),
		.wr_addr (sum_wr_addr),
		.wr_data (sum_wr_data),
		.rd_en   (sum_rd_en),
		.rd_addr (sum_rd_addr),
		.rd_data (sum_rd_data)
	);

	svn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.sum_x  (qs[0]),
		.sum_y  (qs[1]),
		.sum_z  (qs[2]),
		.nout   (nout)
	);

	// Position load: the low POSITION_BITS of each port are kept and read back as
	// signed, so a wider position width sees the port zero-extended.
	assign pos_wr_en   = accept && cmd.kind == svn_pkg::KIND_LOAD && vi_ok;
	assign pos_wr_addr = AW'(cmd.vertex_id);
	assign pos_wr_data = {PB'(unsigned'(cmd.pos_z)), PB'(unsigned'(cmd.pos_y)),
		PB'(unsigned'(cmd.pos_x))};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prd[k] = signed'(pos_rd_data[k*PB +: PB]);
		end
	end

	always_comb begin
		pos_rd_en   = 1'b0;
		pos_rd_addr = AW'(cmd_q.corner_a);
		case (state_q)
			svn_pkg::ST_T_RA: begin
				pos_rd_en   = 1'b1;
				pos_rd_addr = AW'(cmd_q.corner_a);
			end
			svn_pkg::ST_T_RB: begin
				pos_rd_en   = 1'b1;
				pos_rd_addr = AW'(cmd_q.corner_b);
			end
			svn_pkg::ST_T_RC: begin
				pos_rd_en   = 1'b1;
				pos_rd_addr = AW'(cmd_q.corner_c);
			end
			default: begin
			end
		endcase
	end

	// Cross product operands, one pair per step; even steps start a component and
	// odd steps subtract from it.
	always_comb begin
		case (mstep_q)
			3'd0:    begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
			3'd1:    begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
			3'd2:    begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
			3'd3:    begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
			3'd4:    begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
			3'd5:    begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
			default: begin mul_a = '0;      mul_b = '0;      end
		endcase
	end

	// Component that the product of the previous step lands in.
	assign nsel = 2'((mstep_q - 3'd1) >> 1);

	// Corner walk: a repeated index is accumulated only once.
	always_comb begin
		case (cidx_q)
			2'd0: begin
				corner      = cmd_q.corner_a;
				corner_need = 1'b1;
			end
			2'd1: begin
				corner      = cmd_q.corner_b;
				corner_need = cmd_q.corner_b != cmd_q.corner_a;
			end
			2'd2: begin
				corner      = cmd_q.corner_c;
				corner_need = cmd_q.corner_c != cmd_q.corner_a &&
					cmd_q.corner_c != cmd_q.corner_b;
			end
			default: begin
				corner      = cmd_q.corner_a;
				corner_need = 1'b0;
			end
		endcase
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sat[k] = svn_pkg::sat_add(64'(signed'(sum_rd_data[k*SW +: SW])), 64'(n_q[k]));
			qs[k]  = oor_q ? '0 : signed'(sum_rd_data[k*SW +: SW]);
		end
	end

	always_comb begin
		sum_wr_en   = 1'b0;
		sum_wr_addr = clr_q;
		sum_wr_data = '0;
		sum_rd_en   = 1'b0;
		sum_rd_addr = AW'(corner);
		case (state_q)
			svn_pkg::ST_CLEAR: sum_wr_en = 1'b1;
			svn_pkg::ST_T_SRD: sum_rd_en = corner_need;
			svn_pkg::ST_T_SADD: begin
				sum_wr_en   = 1'b1;
				sum_wr_addr = AW'(corner);
				sum_wr_data = {sum_rd_data[RW-1] | sat[0].clip | sat[1].clip | sat[2].clip,
					sat[2].value, sat[1].value, sat[0].value};
			end
			svn_pkg::ST_Q_RD: begin
				sum_rd_en   = 1'b1;
				sum_rd_addr = AW'(cmd_q.vertex_id);
			end
			default: begin
			end
		endcase
	end

	assign norm_start = (state_q == svn_pkg::ST_Q_START);

	always_comb begin
		state_d = state_q;
		case (state_q)
			svn_pkg::ST_CLEAR: begin
				if (clr_q == AW'(VERTEX_COUNT - 1)) begin
					state_d = svn_pkg::ST_IDLE;
				end
			end
			svn_pkg::ST_IDLE: begin
				if (start) begin
					case (cmd.kind)
						svn_pkg::KIND_TRI: begin
							if (tri_ok) begin
								state_d = svn_pkg::ST_T_RA;
							end
						end
						svn_pkg::KIND_QUERY: state_d = svn_pkg::ST_Q_RD;
						default: state_d = svn_pkg::ST_IDLE;
					endcase
				end
			end
			svn_pkg::ST_T_RA:  state_d = svn_pkg::ST_T_RB;
			svn_pkg::ST_T_RB:  state_d = svn_pkg::ST_T_RC;
			svn_pkg::ST_T_RC:  state_d = svn_pkg::ST_T_E2;
			svn_pkg::ST_T_E2:  state_d = svn_pkg::ST_T_MUL;
			svn_pkg::ST_T_MUL: begin
				if (mstep_q == 3'd6) begin
					state_d = svn_pkg::ST_T_SRD;
				end
			end
			svn_pkg::ST_T_SRD: begin
				if (cidx_q == 2'd3) begin
					state_d = svn_pkg::ST_IDLE;
				end else if (corner_need) begin
					state_d = svn_pkg::ST_T_SADD;
				end
			end
			svn_pkg::ST_T_SADD: state_d = svn_pkg::ST_T_SRD;
			svn_pkg::ST_Q_RD:    state_d = svn_pkg::ST_Q_START;
			svn_pkg::ST_Q_START: state_d = svn_pkg::ST_Q_WAIT;
			svn_pkg::ST_Q_WAIT: begin
				if (nout.done) begin
					state_d = svn_pkg::ST_IDLE;
				end
			end
			default: state_d = svn_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svn_pkg::ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == svn_pkg::ST_Q_WAIT) && nout.done;
			if (state_q == svn_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			oor_q <= !vi_ok;
		end
		case (state_q)
			svn_pkg::ST_T_RB: begin
				for (int k = 0; k < 3; k++) begin
					pa_q[k] <= prd[k];
				end
			end
			svn_pkg::ST_T_RC: begin
				for (int k = 0; k < 3; k++) begin
					e1_q[k] <= DW'(prd[k]) - DW'(pa_q[k]);
				end
			end
			svn_pkg::ST_T_E2: begin
				for (int k = 0; k < 3; k++) begin
					e2_q[k] <= DW'(prd[k]) - DW'(pa_q[k]);
				end
				mstep_q <= '0;
			end
			svn_pkg::ST_T_MUL: begin
				prod_q  <= mul_a * mul_b;
				mstep_q <= mstep_q + 3'd1;
				cidx_q  <= '0;
				if (mstep_q != 3'd0) begin
					if (mstep_q[0]) begin
						n_q[nsel] <= NW'(prod_q);
					end else begin
						n_q[nsel] <= n_q[nsel] - NW'(prod_q);
					end
				end
			end
			svn_pkg::ST_T_SRD: begin
				if (!corner_need && cidx_q != 2'd3) begin
					cidx_q <= cidx_q + 2'd1;
				end
			end
			svn_pkg::ST_T_SADD: cidx_q <= cidx_q + 2'd1;
			svn_pkg::ST_Q_START: clip_q <= !oor_q && sum_rd_data[RW-1];
			svn_pkg::ST_Q_WAIT: begin
				if (nout.done) begin
					result_q.out_vertex  <= cmd_q.vertex_id;
					result_q.norm_x      <= nout.nx;
					result_q.norm_y      <= nout.ny;
					result_q.norm_z      <= nout.nz;
					result_q.zero_sum    <= nout.zero;
					result_q.sum_clipped <= clip_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

`include "assert_macros.svh"

	// A result only follows a query that held the block busy.
	`SVN_ASSERT(a_done_after_busy, done |-> $past(busy), "result without a query in flight")
	// An all-zero sum reports zero components.
	`SVN_ASSERT(a_zero_means_zero, done && result.zero_sum |-> result.norm_x == 0 && result.norm_y == 0 && result.norm_z == 0, "zero sum with nonzero components")
	// No component leaves the unit range.
	`SVN_ASSERT_NEVER(a_unit_range, done && (result.norm_x > 16384 || result.norm_x < -16384 || result.norm_y > 16384 || result.norm_y < -16384 || result.norm_z > 16384 || result.norm_z < -16384), "component outside unit range")
	// The normalizer finishes only while a query waits for it.
	`SVN_ASSERT(a_norm_done_in_wait, nout.done |-> state_q == svn_pkg::ST_Q_WAIT, "normalizer finished outside a query")

endmodule
